[sv/esd_pkg.sv]
// ----------------------------------------------------------------------------
// esd_pkg - shared types and helpers for the escape sequence decoder
// Transaction structs, decode phase codes and character classifiers.
// ----------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ESCAPE = 8'h1B;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef enum logic [2:0] {
    PH_PLAIN = 3'd0,
    PH_ESC   = 3'd1,
    PH_OCT1  = 3'd2,
    PH_OCT2  = 3'd3,
    PH_HEX0  = 3'd4,
    PH_HEX1  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;
  } result_t;

  // Decode of one item: up to two results plus the state it leaves behind.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
    phase_t     phase_next;
    logic [7:0] accum_next;
  } dec_t;

  // {hit, mapped byte} for the single-character escapes
  function automatic logic [8:0] simple_escape(input logic [7:0] b);
    logic [8:0] r;
    r = {1'b1, b};
    case (b) inside
      8'h5C, 8'h22, 8'h27, 8'h7C, 8'h3E, 8'h3C, 8'h26, 8'h24, 8'h23, 8'h20: r = {1'b1, b};
      8'h65:   r = {1'b1, CH_ESCAPE};
      8'h6E:   r = {1'b1, CH_LF};
      8'h72:   r = {1'b1, CH_CR};
      8'h74:   r = {1'b1, CH_TAB};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_octal(input logic [7:0] b);
    return (b inside {[8'h30:8'h37]});
  endfunction

  // {hit, nibble value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, b[3:0]};
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, 4'(b[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/esd_decode.sv]
// ----------------------------------------------------------------------------
// esd_decode - escape decode logic
// Maps current phase, accumulator and one input item to results and next state.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_decode (
  input  var esd_pkg::phase_t phase,
  input  wire logic [7:0]     accum,
  input  var esd_pkg::item_t  item,
  output var esd_pkg::dec_t   dec
);

  logic [7:0]      b;
  logic [8:0]      simple;
  logic [4:0]      hex;
  logic            pre_hit;
  logic [7:0]      pre_byte;
  logic            ordinary;
  logic            ord_emit;
  esd_pkg::phase_t ph;
  logic [7:0]      acc;
  logic [1:0]      n;
  esd_pkg::result_t r0;
  esd_pkg::result_t r1;

  always_comb begin
    b        = item.in_byte;
    simple   = esd_pkg::simple_escape(b);
    hex      = esd_pkg::hex_digit(b);
    pre_hit  = 1'b0;
    pre_byte = 8'd0;
    ordinary = 1'b0;
    ord_emit = 1'b0;
    ph       = phase;
    acc      = accum;

    case (phase)
      esd_pkg::PH_ESC: begin
        if (simple[8]) begin
          pre_hit  = 1'b1;
          pre_byte = simple[7:0];
          ph       = esd_pkg::PH_PLAIN;
        end else if (esd_pkg::is_octal(b)) begin
          acc = {5'd0, b[2:0]};
          ph  = esd_pkg::PH_OCT1;
        end else if (b == 8'h78 || b == 8'h58) begin
          acc = 8'd0;
          ph  = esd_pkg::PH_HEX0;
        end else begin
          pre_hit  = 1'b1;
          pre_byte = esd_pkg::CH_BSLASH;
          ordinary = 1'b1;
        end
      end
      esd_pkg::PH_OCT1: begin
        if (esd_pkg::is_octal(b)) begin
          acc = {accum[4:0], b[2:0]};
          ph  = esd_pkg::PH_OCT2;
        end else begin
          pre_hit  = 1'b1;
          pre_byte = accum;
          ordinary = 1'b1;
        end
      end
      esd_pkg::PH_OCT2: begin
        pre_hit = 1'b1;
        if (esd_pkg::is_octal(b)) begin
          pre_byte = {accum[4:0], b[2:0]};
          ph       = esd_pkg::PH_PLAIN;
        end else begin
          pre_byte = accum;
          ordinary = 1'b1;
        end
      end
      esd_pkg::PH_HEX0: begin
        if (hex[4]) begin
          acc = {4'd0, hex[3:0]};
          ph  = esd_pkg::PH_HEX1;
        end else begin
          pre_hit  = 1'b1;
          pre_byte = 8'd0;
          ordinary = 1'b1;
        end
      end
      esd_pkg::PH_HEX1: begin
        pre_hit = 1'b1;
        if (hex[4]) begin
          pre_byte = {accum[3:0], hex[3:0]};
          ph       = esd_pkg::PH_PLAIN;
        end else begin
          pre_byte = accum;
          ordinary = 1'b1;
        end
      end
      default: ordinary = 1'b1;
    endcase

    if (ordinary) begin
      if (b == esd_pkg::CH_BSLASH) begin
        ph = esd_pkg::PH_ESC;
      end else begin
        ph       = esd_pkg::PH_PLAIN;
        ord_emit = 1'b1;
      end
    end

    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    if (pre_hit) begin
      r0 = '{out_byte: pre_byte, has_byte: 1'b1, out_last: 1'b0};
      n  = 2'd1;
      if (ord_emit) begin
        r1 = '{out_byte: b, has_byte: 1'b1, out_last: 1'b0};
        n  = 2'd2;
      end
    end else if (ord_emit) begin
      r0 = '{out_byte: b, has_byte: 1'b1, out_last: 1'b0};
      n  = 2'd1;
    end

    // End of stream: flush a pending digit value (only possible with no
    // result so far), then mark the final result.
    if (item.in_last) begin
      if (ph == esd_pkg::PH_OCT1 || ph == esd_pkg::PH_OCT2 || ph == esd_pkg::PH_HEX1) begin
        r0 = '{out_byte: acc, has_byte: 1'b1, out_last: 1'b0};
        n  = 2'd1;
      end else if (ph == esd_pkg::PH_HEX0) begin
        r0 = '{out_byte: 8'd0, has_byte: 1'b1, out_last: 1'b0};
        n  = 2'd1;
      end
      ph  = esd_pkg::PH_PLAIN;
      acc = 8'd0;
      if (n == 2'd0) begin
        n = 2'd1;
      end
      if (n == 2'd2) begin
        r1.out_last = 1'b1;
      end else begin
        r0.out_last = 1'b1;
      end
    end

    dec.count      = n;
    dec.res0       = r0;
    dec.res1       = r1;
    dec.phase_next = ph;
    dec.accum_next = acc;
  end

endmodule

`default_nettype wire

[sv/esd_out_stage.sv]
// ----------------------------------------------------------------------------
// esd_out_stage - result register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  var esd_pkg::result_t  din,
  output logic                  free,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output esd_pkg::result_t      result
);

  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= din;
    end
  end

endmodule

`default_nettype wire

[sv/escape_sequence_decoder_top.sv]
// ----------------------------------------------------------------------------
// escape_sequence_decoder_top - backslash escape decoder
// Decodes a byte stream with C/shell style backslash escapes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall / item) carries one raw byte and
//   a last flag per transaction. Output channel (result_valid /
//   result_stall / result) carries decoded bytes; has_byte is 0 only on a
//   bare end marker, out_last marks the final result of a last item.
//   An item produces zero, one or two results. An item with no result
//   (a backslash, or a digit inside an escape) is absorbed silently.
//   A result passes from the input register (written when its item is
//   accepted) to the result register and from there to the output.
//   Throughput: one item per cycle while the receiver does not stall;
//   an item with two results holds the input register until its second
//   result is loaded, and the two results leave in order.
//   Reset (rst, synchronous): both registers empty, decoder back in the
//   plain text phase with a cleared accumulator.
//   When the receiver stalls, the result register holds its transaction
//   and the input register fills; item_stall then rises so no transaction
//   is dropped. The input register is taken again in the same cycle the
//   held result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_decoder_top (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  var esd_pkg::item_t    item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output esd_pkg::result_t      result
);

  // input register
  logic             item_held;
  esd_pkg::item_t   item_q;
  // which result of the held item goes out next
  logic             sel;
  // decoder state, updated once the held item is fully retired
  esd_pkg::phase_t  phase;
  logic [7:0]       accum;

  esd_pkg::dec_t    dec;
  esd_pkg::result_t cur;
  logic             out_free;
  logic             step;
  logic             load;
  logic             final_res;
  logic             retire;

  esd_decode u_decode (
    .phase (phase),
    .accum (accum),
    .item  (item_q),
    .dec   (dec)
  );

  assign cur       = sel ? dec.res1 : dec.res0;
  // last result of the held item once sel matches count - 1
  assign final_res = (dec.count == 2'd0) || (sel == dec.count[1]);
  // an item without results advances without touching the output
  assign step      = item_held && ((dec.count == 2'd0) || out_free);
  assign load      = item_held && (dec.count != 2'd0) && out_free;
  assign retire    = step && final_res;
  assign item_stall = item_held && !retire;

  esd_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .din          (cur),
    .free         (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_held <= 1'b0;
      sel       <= 1'b0;
      phase     <= esd_pkg::PH_PLAIN;
      accum     <= 8'd0;
    end else begin
      if (!item_stall) begin
        item_held <= item_valid;
      end
      if (retire) begin
        sel   <= 1'b0;
        phase <= dec.phase_next;
        accum <= dec.accum_next;
      end else if (step) begin
        sel <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q <= item;
    end
  end

endmodule

`default_nettype wire
